FILE: design/wgm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the wildcard glob matcher.
package wgm_pkg;

    // Width of the symbol field on the request channel.
    localparam int unsigned SYMBOL_FIELD_W = 16;

    // Wildcard symbols in a pattern.
    localparam logic [SYMBOL_FIELD_W-1:0] SYM_STAR     = 16'd42;
    localparam logic [SYMBOL_FIELD_W-1:0] SYM_QUESTION = 16'd63;

    // Request commands.
    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_TEXT   = 2'd2,
        CMD_END    = 2'd3
    } cmd_t;

    // Strobes broadcast from the control logic to every cell.
    typedef struct packed {
        logic clear;    // forget the pattern
        logic append;   // store the symbol in the first empty cell
        logic consume;  // advance the live set over one text symbol
        logic restart;  // return the live set to position zero
    } ctrl_t;

    // Signals handed from one cell to the next.
    typedef struct packed {
        logic valid;    // the cell holds a pattern symbol
        logic carry;    // star closure: the next position is live too
        logic step;     // the next position becomes live after this symbol
    } link_t;

endpackage

FILE: design/wgm_in_if.sv
`timescale 1ns / 1ps
// Request channel carrying a command and a symbol.
interface wgm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [15:0] symbol;

    modport source (output valid, output cmd, output symbol, input ready);
    modport sink (input valid, input cmd, input symbol, output ready);
endinterface

FILE: design/wgm_out_if.sv
`timescale 1ns / 1ps
// Result channel carrying the match verdict and the error flag.
interface wgm_out_if;
    logic valid;
    logic ready;
    logic matched;
    logic error;

    modport source (output valid, output matched, output error, input ready);
    modport sink (input valid, input matched, input error, output ready);
endinterface

FILE: design/wgm_cell.sv
`timescale 1ns / 1ps
// One pattern position: its symbol, its live bit and the links to its neighbours.
module wgm_cell
    import wgm_pkg::*;
#(
    parameter int unsigned SYM_W = 16,
    parameter bit          HEAD  = 1'b0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ctrl_t            ctrl,
    input  logic [SYM_W-1:0] sym,
    input  link_t            link_in,
    output link_t            link_out,
    output logic             end_hit
);

    logic             valid_reg;
    logic             valid_next;
    logic             live_reg;
    logic             live_next;
    logic [SYM_W-1:0] sym_reg;
    logic             is_star_reg;
    logic             is_quest_reg;
    logic             load;
    logic             closed;

    // The cell loads when its predecessor is full and it is still empty.
    assign load = ctrl.append && link_in.valid && !valid_reg;

    // Live after closing the stars in front of this position.
    assign closed = live_reg || link_in.carry;

    assign link_out.valid = valid_reg;
    assign link_out.carry = closed && valid_reg && is_star_reg;
    assign link_out.step  = closed && valid_reg && !is_star_reg &&
                            (is_quest_reg || (sym_reg == sym));

    // The first empty position that is live marks the end of the pattern reached.
    assign end_hit = closed && !valid_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (load)
        begin
            valid_next = 1'b1;
        end
    end

    // A star keeps its own position live; any other match moves one on.
    always_comb
    begin
        priority if (ctrl.restart)
        begin
            live_next = HEAD;
        end
        else if (ctrl.consume)
        begin
            live_next = link_out.carry || link_in.step;
        end
        else
        begin
            live_next = live_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            live_reg  <= HEAD;
        end
        else
        begin
            valid_reg <= valid_next;
            live_reg  <= live_next;
        end
    end

    // Symbol store, decoded once when it is written.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sym_reg      <= sym;
            is_star_reg  <= (sym == SYM_STAR[SYM_W-1:0]);
            is_quest_reg <= (sym == SYM_QUESTION[SYM_W-1:0]);
        end
    end

endmodule

FILE: design/wildcard_glob_matcher.sv
`timescale 1ns / 1ps
// Top level of the wildcard glob matcher: command decode, cell row and result register.
//
// Usage. Requests arrive on the item channel, each a command and a symbol.
// CMD_CLEAR forgets the pattern, the text and the error flag. CMD_APPEND adds
// one pattern symbol ('*' any run, '?' any one symbol); it is ignored once text
// has started. CMD_TEXT streams one text symbol. CMD_END asks for the verdict,
// which is the only request that gives a result: matched and error on the
// result channel. The pattern is kept across verdicts; only a clear drops it.
// Appending beyond PATTERN_MAX symbols or sending a zero text symbol sets the
// error flag, which forces matched low until the next clear.
// Throughput: one request per cycle while no verdict is stalled, with all cells
// updated at once. The verdict is registered in the cycle after CMD_END is taken.
// The longest path is the star closure rippling through the row of cells.
// If the receiver stalls, the verdict waits in the result register and further
// requests are held off only while that register is full and not being taken.
// Reset empties the pattern, clears the error flag and the result register,
// and leaves only position zero live.
module wildcard_glob_matcher
    import wgm_pkg::*;
#(
    parameter int unsigned PATTERN_MAX = 32,
    parameter int unsigned SYMBOL_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    wgm_in_if.sink     item,
    wgm_out_if.source  result
);

    localparam int unsigned SymW = (SYMBOL_BITS < SYMBOL_FIELD_W) ? SYMBOL_BITS
                                                                   : SYMBOL_FIELD_W;

    link_t                  links [PATTERN_MAX+1];
    logic [PATTERN_MAX-1:0] end_hits;
    ctrl_t                  ctrl;
    logic [SymW-1:0]        sym;
    logic                   item_acc;
    logic                   do_end;
    logic                   overflow;
    logic                   zero_text;
    logic                   hit;
    logic                   closed_last;
    logic                   live_last_reg;
    logic                   live_last_next;
    logic                   started_reg;
    logic                   started_next;
    logic                   err_flag_reg;
    logic                   err_flag_next;
    logic                   res_valid_reg;
    logic                   res_valid_next;
    logic                   matched_reg;
    logic                   error_reg;

    assign item.ready = !res_valid_reg || result.ready;
    assign item_acc   = item.valid && item.ready;
    assign sym        = item.symbol[SymW-1:0];
    assign zero_text  = (sym == '0);

    // Command decode into cell strobes.
    always_comb
    begin
        ctrl     = '0;
        do_end   = 1'b0;
        overflow = 1'b0;
        if (item_acc)
        begin
            unique case (cmd_t'(item.cmd))
                CMD_CLEAR:
                begin
                    ctrl.clear   = 1'b1;
                    ctrl.restart = 1'b1;
                end
                CMD_APPEND:
                begin
                    ctrl.append = !started_reg;
                    overflow    = !started_reg && links[PATTERN_MAX].valid;
                end
                CMD_TEXT:
                begin
                    ctrl.consume = !zero_text;
                end
                CMD_END:
                begin
                    do_end       = 1'b1;
                    ctrl.restart = 1'b1;
                end
                default:
                begin
                    ctrl = '0;
                end
            endcase
        end
    end

    // Row of pattern cells; the head cell always sees a full predecessor.
    assign links[0] = '{valid: 1'b1, carry: 1'b0, step: 1'b0};

    for (genvar gi = 0; gi < PATTERN_MAX; gi++)
    begin : g_cell
        wgm_cell #(
            .SYM_W (SymW),
            .HEAD  (gi == 0)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .sym      (sym),
            .link_in  (links[gi]),
            .link_out (links[gi+1]),
            .end_hit  (end_hits[gi])
        );
    end

    // Position after the last cell, reached only with a full pattern.
    assign closed_last = live_last_reg || links[PATTERN_MAX].carry;
    assign hit         = (|end_hits) || closed_last;

    always_comb
    begin
        priority if (ctrl.restart)
        begin
            live_last_next = 1'b0;
        end
        else if (ctrl.consume)
        begin
            live_last_next = links[PATTERN_MAX].carry || links[PATTERN_MAX].step;
        end
        else
        begin
            live_last_next = live_last_reg;
        end
    end

    // Text and error tracking.
    always_comb
    begin
        started_next = started_reg;
        if (ctrl.restart)
        begin
            started_next = 1'b0;
        end
        else if (item_acc && (cmd_t'(item.cmd) == CMD_TEXT))
        begin
            started_next = 1'b1;
        end

        err_flag_next = err_flag_reg;
        if (ctrl.clear)
        begin
            err_flag_next = 1'b0;
        end
        else if (overflow || (item_acc && (cmd_t'(item.cmd) == CMD_TEXT) && zero_text))
        begin
            err_flag_next = 1'b1;
        end
    end

    // Result register valid flag.
    always_comb
    begin
        priority if (do_end)
        begin
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_last_reg <= 1'b0;
            started_reg   <= 1'b0;
            err_flag_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            live_last_reg <= live_last_next;
            started_reg   <= started_next;
            err_flag_reg  <= err_flag_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Verdict payload, captured when the end-of-text request is taken.
    always_ff @(posedge clk)
    begin
        if (do_end)
        begin
            matched_reg <= hit && !err_flag_reg;
            error_reg   <= err_flag_reg;
        end
    end

    assign result.valid   = res_valid_reg;
    assign result.matched = matched_reg;
    assign result.error   = error_reg;

    // A fresh result only follows an accepted end-of-text request.
    a_result_from_end : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(do_end))
        else $error("result raised without an end-of-text request");

    // A clear empties the head cell.
    a_clear_empties : assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.clear |=> !links[1].valid)
        else $error("head cell still loaded after a clear");

    // Appends are ignored once text has started.
    a_append_frozen : assert property (@(posedge clk) disable iff (!rst_n)
        (item_acc && (cmd_t'(item.cmd) == CMD_APPEND) && started_reg)
        |=> $stable(links[PATTERN_MAX].valid) && $stable(links[1].valid))
        else $error("pattern changed while text was streaming");

    // Overflowing the pattern store raises the error flag.
    a_overflow_flags : assert property (@(posedge clk) disable iff (!rst_n)
        overflow |=> err_flag_reg)
        else $error("pattern overflow did not set the error flag");

    // A verdict never claims a match while reporting an error.
    a_no_match_on_error : assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> !(matched_reg && error_reg))
        else $error("match reported together with an error");

endmodule
